// ===== rtl/core/iaf_pkg.sv =====
`default_nettype none

package iaf_pkg;

   // Field widths of the request and response words.
   localparam int VALUE_W = 64;
   localparam int SIZE_W  = 2;
   localparam int FUNC_W  = 3;
   localparam int CHAR_W  = 7;

   // Operand size codes.
   localparam logic [SIZE_W-1:0] SIZE_16 = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_32 = 2'd1;

   // Conversion kinds.
   localparam logic [FUNC_W-1:0] FUNC_SDEC  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_UDEC  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_OCT   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_HEXL  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_HEXU  = 3'd4;

   // Character offsets.
   localparam logic [CHAR_W-1:0] CHR_ZERO      = 7'd48;
   localparam logic [CHAR_W-1:0] CHR_LOWER_OFS = 7'd87;
   localparam logic [CHAR_W-1:0] CHR_UPPER_OFS = 7'd55;
   localparam logic [CHAR_W-1:0] CHR_MINUS     = 7'd45;

   // Digit register: twenty BCD digits, also large enough for 22 octal digits.
   localparam int NUM_DIGITS = 20;
   localparam int DIGIT_W    = 4 * NUM_DIGITS;

endpackage

`default_nettype wire

// ===== rtl/core/iaf_if.sv =====
`default_nettype none

// Request channel: one integer with its size and conversion kind.
interface iaf_req_if;
   logic                          valid;
   logic                          ready;
   logic [iaf_pkg::VALUE_W-1:0]   value;
   logic [iaf_pkg::SIZE_W-1:0]    size;
   logic [iaf_pkg::FUNC_W-1:0]    func;

   modport source (output valid, value, size, func, input ready);
   modport sink   (input valid, value, size, func, output ready);
endinterface

// Response channel: one ASCII character per word.
interface iaf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [iaf_pkg::CHAR_W-1:0]    char_code;
   logic                          last;

   modport source (output valid, char_code, last, input ready);
   modport sink   (input valid, char_code, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter_core.sv =====
`default_nettype none

// Channel    Direction  Word contents
// req_bus    in         value[63:0], size[1:0], func[2:0]
// rsp_bus    out        char_code[6:0], last
//
// Decimal conversion runs a shift-and-add-3 pass over the 16, 32 or 64 operand
// bits, one operand bit per cycle, then scans 20 BCD digits one per cycle, top first.
// Octal and hex skip the pass and scan 6/11/22 or 4/8/16 digits directly.
// Leading zeros are dropped without a word; a stalled response holds the scan.
// A request is taken only when the previous number has been fully handed off
// to the response register. Reset is synchronous and clears control state.
module integer_to_ascii_formatter_core (
   input  wire logic     clock,
   input  wire logic     reset,
   iaf_req_if.sink       req_bus,
   iaf_rsp_if.source     rsp_bus
);

   localparam int VW = iaf_pkg::VALUE_W;
   localparam int DW = iaf_pkg::DIGIT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic [DW-1:0]                 dig_ff, dig_in;
   logic [VW-1:0]                 src_ff, src_in;
   logic [6:0]                    cyc_ff, cyc_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [iaf_pkg::FUNC_W-1:0]    fn_ff, fn_in;
   logic                          neg_ff, neg_in;
   logic                          lead_ff, lead_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [iaf_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [VW-1:0]                 masked;
   logic [VW-1:0]                 mag;
   logic                          sign_bit;
   logic [DW-1:0]                 adj;
   logic [3:0]                    digit;
   logic [iaf_pkg::CHAR_W-1:0]    digit_char;
   logic                          out_free;
   logic                          is_oct;

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_code = rsp_char_ff;
   assign rsp_bus.last      = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign is_oct   = (fn_ff == iaf_pkg::FUNC_OCT);

   // Operand masked to its size, and its magnitude for signed decimal.
   always_comb begin
      unique case (req_bus.size)
         iaf_pkg::SIZE_16: begin
            masked   = {48'd0, req_bus.value[15:0]};
            sign_bit = req_bus.value[15];
         end
         iaf_pkg::SIZE_32: begin
            masked   = {32'd0, req_bus.value[31:0]};
            sign_bit = req_bus.value[31];
         end
         default: begin
            masked   = req_bus.value;
            sign_bit = req_bus.value[63];
         end
      endcase
      mag = masked;
      if (req_bus.func == iaf_pkg::FUNC_SDEC && sign_bit) begin
         mag = ~masked + VW'(1);
         unique case (req_bus.size)
            iaf_pkg::SIZE_16: mag = {48'd0, mag[15:0]};
            iaf_pkg::SIZE_32: mag = {32'd0, mag[31:0]};
            default:          mag = mag;
         endcase
      end
   end

   // Add 3 to every BCD digit of five or more before the next shift.
   always_comb begin
      for (int i = 0; i < iaf_pkg::NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ? dig_ff[4*i +: 4] + 4'd3
                                                     : dig_ff[4*i +: 4];
      end
   end

   // Top digit of the scan and its character.
   always_comb begin
      digit = is_oct ? {1'b0, dig_ff[DW-1 -: 3]} : dig_ff[DW-1 -: 4];
      if (digit > 4'd9) begin
         digit_char = {3'd0, digit} + ((fn_ff == iaf_pkg::FUNC_HEXL)
                      ? iaf_pkg::CHR_LOWER_OFS : iaf_pkg::CHR_UPPER_OFS);
      end else begin
         digit_char = {3'd0, digit} + iaf_pkg::CHR_ZERO;
      end
   end

   // Next-state logic of the sequencer and the response register.
   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      src_in       = src_ff;
      cyc_in       = cyc_ff;
      cnt_in       = cnt_ff;
      fn_in        = fn_ff;
      neg_in       = neg_ff;
      lead_in      = lead_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               fn_in   = req_bus.func;
               neg_in  = (req_bus.func == iaf_pkg::FUNC_SDEC) && sign_bit;
               lead_in = 1'b1;
               unique case (req_bus.func) inside
                  iaf_pkg::FUNC_SDEC, iaf_pkg::FUNC_UDEC: begin
                     state_in = ST_CONV;
                     dig_in   = '0;
                     cnt_in   = 5'(iaf_pkg::NUM_DIGITS);
                     unique case (req_bus.size)
                        iaf_pkg::SIZE_16: begin
                           src_in = {mag[15:0], 48'd0};
                           cyc_in = 7'd16;
                        end
                        iaf_pkg::SIZE_32: begin
                           src_in = {mag[31:0], 32'd0};
                           cyc_in = 7'd32;
                        end
                        default: begin
                           src_in = mag;
                           cyc_in = 7'd64;
                        end
                     endcase
                  end
                  iaf_pkg::FUNC_OCT: begin
                     state_in = ST_EMIT;
                     unique case (req_bus.size)
                        iaf_pkg::SIZE_16: begin
                           dig_in = {2'd0, masked[15:0], 62'd0};
                           cnt_in = 5'd6;
                        end
                        iaf_pkg::SIZE_32: begin
                           dig_in = {1'b0, masked[31:0], 47'd0};
                           cnt_in = 5'd11;
                        end
                        default: begin
                           dig_in = {2'd0, masked, 14'd0};
                           cnt_in = 5'd22;
                        end
                     endcase
                  end
                  iaf_pkg::FUNC_HEXL, iaf_pkg::FUNC_HEXU: begin
                     state_in = ST_EMIT;
                     unique case (req_bus.size)
                        iaf_pkg::SIZE_16: begin
                           dig_in = {masked[15:0], 64'd0};
                           cnt_in = 5'd4;
                        end
                        iaf_pkg::SIZE_32: begin
                           dig_in = {masked[31:0], 48'd0};
                           cnt_in = 5'd8;
                        end
                        default: begin
                           dig_in = {masked, 16'd0};
                           cnt_in = 5'd16;
                        end
                     endcase
                  end
                  default: begin
                     // Unknown conversion kinds print nothing.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            dig_in = {adj[DW-2:0], src_ff[VW-1]};
            src_in = {src_ff[VW-2:0], 1'b0};
            cyc_in = cyc_ff - 7'd1;
            if (cyc_ff == 7'd1) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = iaf_pkg::CHR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (lead_ff && digit == 4'd0 && cnt_ff != 5'd1) begin
               // Leading zero: drop it without a word.
               dig_in = is_oct ? {dig_ff[DW-4:0], 3'd0} : {dig_ff[DW-5:0], 4'd0};
               cnt_in = cnt_ff - 5'd1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char;
               rsp_last_in  = (cnt_ff == 5'd1);
               lead_in      = 1'b0;
               dig_in = is_oct ? {dig_ff[DW-4:0], 3'd0} : {dig_ff[DW-5:0], 4'd0};
               cnt_in = cnt_ff - 5'd1;
               if (cnt_ff == 5'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lead_ff      <= 1'b0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lead_ff      <= lead_in;
         neg_ff       <= neg_in;
      end
      dig_ff      <= dig_in;
      src_ff      <= src_in;
      cyc_ff      <= cyc_in;
      cnt_ff      <= cnt_in;
      fn_ff       <= fn_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_integer_to_ascii_formatter_core.sv =====
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter_core;

   // Codes the package leaves unnamed.
   localparam logic [iaf_pkg::SIZE_W-1:0] SIZE_64       = 2'd2;
   localparam logic [iaf_pkg::SIZE_W-1:0] SIZE_64_ALIAS = 2'd3;
   localparam logic [iaf_pkg::FUNC_W-1:0] FUNC_RSVD5    = 3'd5;
   localparam logic [iaf_pkg::FUNC_W-1:0] FUNC_RSVD6    = 3'd6;
   localparam logic [iaf_pkg::FUNC_W-1:0] FUNC_RSVD7    = 3'd7;

   localparam int MAX_CHARS   = 22;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_WAIT  = 200;

   typedef struct packed {
      logic [iaf_pkg::CHAR_W-1:0] char_code;
      logic                       last;
   } char_word_type;

   logic clock;
   logic reset;

   iaf_req_if req_bus ();
   iaf_rsp_if rsp_bus ();

   integer_to_ascii_formatter_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   char_word_type pending_chars[$];
   int            error_count;
   int            idle_cycles;
   bit            no_idle;
   bit            hold_rsp_request;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
   endtask

   // Works out the characters of one number and queues them in order.
   function automatic void queue_number_chars(
         input logic [iaf_pkg::VALUE_W-1:0] value,
         input logic [iaf_pkg::SIZE_W-1:0]  size,
         input logic [iaf_pkg::FUNC_W-1:0]  func);
      logic [iaf_pkg::VALUE_W-1:0] mag;
      logic [iaf_pkg::VALUE_W-1:0] mask;
      logic [iaf_pkg::VALUE_W-1:0] digit;
      logic [iaf_pkg::CHAR_W-1:0]  glyph;
      logic [iaf_pkg::CHAR_W-1:0]  digit_chars[$];
      int                          width;
      bit                          negative;
      char_word_type               cw;

      negative = 1'b0;
      if (func > iaf_pkg::FUNC_HEXU) begin
         return;
      end
      case (size)
         iaf_pkg::SIZE_16: width = 16;
         iaf_pkg::SIZE_32: width = 32;
         default:          width = 64;
      endcase
      mask = (width == 64) ? {iaf_pkg::VALUE_W{1'b1}} : ((64'd1 << width) - 64'd1);
      mag  = value & mask;

      // A negative signed operand prints as minus and its magnitude.
      if (func == iaf_pkg::FUNC_SDEC && mag[width-1]) begin
         negative = 1'b1;
         mag      = (~mag + 64'd1) & mask;
      end

      // Digits come out least significant first; build the string front-first.
      do begin
         if (func == iaf_pkg::FUNC_OCT) begin
            digit = mag & 64'd7;
            mag   = mag >> 3;
         end else if (func == iaf_pkg::FUNC_HEXL || func == iaf_pkg::FUNC_HEXU) begin
            digit = mag & 64'd15;
            mag   = mag >> 4;
         end else begin
            digit = mag % 64'd10;
            mag   = mag / 64'd10;
         end
         if (digit > 64'd9) begin
            glyph = digit[iaf_pkg::CHAR_W-1:0] + ((func == iaf_pkg::FUNC_HEXL)
                    ? iaf_pkg::CHR_LOWER_OFS : iaf_pkg::CHR_UPPER_OFS);
         end else begin
            glyph = digit[iaf_pkg::CHAR_W-1:0] + iaf_pkg::CHR_ZERO;
         end
         digit_chars.push_front(glyph);
      end while (mag != 64'd0 && digit_chars.size() < MAX_CHARS);

      if (negative) begin
         cw.char_code = iaf_pkg::CHR_MINUS;
         cw.last      = 1'b0;
         pending_chars.push_back(cw);
      end
      foreach (digit_chars[i]) begin
         cw.char_code = digit_chars[i];
         cw.last      = (i == digit_chars.size() - 1);
         pending_chars.push_back(cw);
      end
   endfunction

   // Every accepted request word adds its characters to the pending list.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         queue_number_chars(req_bus.value, req_bus.size, req_bus.func);
      end
   end

   // Every accepted response word is checked against the oldest pending one.
   always @(posedge clock) begin
      char_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected word char=%0d last=%0b",
                                      rsp_bus.char_code, rsp_bus.last));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_bus.char_code !== want.char_code) begin
               report_mismatch($sformatf("char_code got %0d want %0d",
                                         rsp_bus.char_code, want.char_code));
            end
            if (rsp_bus.last !== want.last) begin
               report_mismatch($sformatf("last got %0b want %0b (char %0d)",
                                         rsp_bus.last, want.last, want.char_code));
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles", idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response receiver: random gaps per word, plus a long hold when asked.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp_request = 1'b0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Sends one request word after a random gap and waits for it to be taken.
   task automatic send_number(input logic [iaf_pkg::VALUE_W-1:0] value,
                              input logic [iaf_pkg::SIZE_W-1:0]  size,
                              input logic [iaf_pkg::FUNC_W-1:0]  func);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      req_bus.size  <= size;
      req_bus.func  <= func;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Random operand with a random bit length, so short numbers show up too.
   function automatic logic [iaf_pkg::VALUE_W-1:0] random_value();
      logic [iaf_pkg::VALUE_W-1:0] v;
      int                          bits;
      v    = {$urandom, $urandom};
      bits = $urandom_range(1, 64);
      if (bits < 64) begin
         v = v & ((64'd1 << bits) - 64'd1);
      end
      return v;
   endfunction

   // Mostly real conversions, now and then an unused code.
   function automatic logic [iaf_pkg::FUNC_W-1:0] random_func();
      if ($urandom_range(0, 19) < 18) begin
         return iaf_pkg::FUNC_W'($urandom_range(0, 4));
      end
      return iaf_pkg::FUNC_W'($urandom_range(5, 7));
   endfunction

   // Extremes of several sizes and kinds, zero, the most negative values,
   // the unused size and conversion codes, and ignored upper operand bits.
   task automatic test_directed();
      send_number(64'd0, iaf_pkg::SIZE_16, iaf_pkg::FUNC_SDEC);
      send_number(64'd0, SIZE_64, iaf_pkg::FUNC_HEXL);
      send_number(64'd0, iaf_pkg::SIZE_32, iaf_pkg::FUNC_OCT);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, SIZE_64, iaf_pkg::FUNC_UDEC);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, SIZE_64, iaf_pkg::FUNC_OCT);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, SIZE_64, iaf_pkg::FUNC_SDEC);
      send_number(64'h8000_0000_0000_0000, SIZE_64, iaf_pkg::FUNC_SDEC);
      send_number(64'h0000_0000_0000_8000, iaf_pkg::SIZE_16, iaf_pkg::FUNC_SDEC);
      send_number(64'h0000_0000_8000_0000, iaf_pkg::SIZE_32, iaf_pkg::FUNC_SDEC);
      send_number(64'h0000_0000_0000_7FFF, iaf_pkg::SIZE_16, iaf_pkg::FUNC_SDEC);
      send_number(64'h7FFF_FFFF_FFFF_FFFF, SIZE_64, iaf_pkg::FUNC_SDEC);
      send_number(64'h0000_0000_0000_FFFF, iaf_pkg::SIZE_16, iaf_pkg::FUNC_OCT);
      send_number(64'h0000_0000_FFFF_FFFF, iaf_pkg::SIZE_32, iaf_pkg::FUNC_OCT);
      send_number(64'h0000_0000_DEAD_BEEF, iaf_pkg::SIZE_32, iaf_pkg::FUNC_HEXL);
      send_number(64'h0000_0000_DEAD_BEEF, iaf_pkg::SIZE_32, iaf_pkg::FUNC_HEXU);
      send_number(64'h0123_4567_89AB_CDEF, SIZE_64, iaf_pkg::FUNC_HEXU);
      send_number(64'hFEDC_BA98_7654_3210, SIZE_64, iaf_pkg::FUNC_HEXL);
      send_number(64'hFFFF_FFFF_FFFF_1234, iaf_pkg::SIZE_16, iaf_pkg::FUNC_UDEC);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, SIZE_64_ALIAS, iaf_pkg::FUNC_UDEC);
      send_number(64'h8000_0000_0000_0000, SIZE_64_ALIAS, iaf_pkg::FUNC_SDEC);
      send_number(64'h0000_0000_0000_1234, iaf_pkg::SIZE_16, FUNC_RSVD5);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, SIZE_64, FUNC_RSVD6);
      send_number(64'h0000_0000_0000_0009, iaf_pkg::SIZE_32, FUNC_RSVD7);
      send_number(64'h0000_0000_0000_0009, iaf_pkg::SIZE_32, iaf_pkg::FUNC_UDEC);
      send_number(64'h0000_0000_0000_000A, iaf_pkg::SIZE_16, iaf_pkg::FUNC_HEXL);
   endtask

   // Random operands, sizes and conversion kinds with random gaps.
   task automatic test_random_mix(input int count);
      repeat (count) begin
         send_number(random_value(), iaf_pkg::SIZE_W'($urandom_range(0, 3)),
                     random_func());
      end
   endtask

   // Both sides without gaps.
   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      repeat (count) begin
         send_number(random_value(), iaf_pkg::SIZE_W'($urandom_range(0, 3)),
                     random_func());
      end
      no_idle = 1'b0;
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure(input int count);
      hold_rsp_request = 1'b1;
      repeat (count) begin
         send_number(random_value(), iaf_pkg::SIZE_W'($urandom_range(0, 3)),
                     iaf_pkg::FUNC_W'($urandom_range(0, 4)));
      end
   endtask

   // Main sequence.
   initial begin
      error_count      = 0;
      no_idle          = 1'b0;
      hold_rsp_request = 1'b0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.value    <= '0;
      req_bus.size     <= iaf_pkg::SIZE_16;
      req_bus.func     <= iaf_pkg::FUNC_SDEC;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(150);
      test_output_backpressure(30);
      test_back_to_back(60);
      test_random_mix(150);
      req_bus.valid <= 1'b0;

      // Drain, then give a stray word time to show up.
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
